@@ design/mtfw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtfw_pkg
// Shared types and constants for the mutex table with per-slot wait queues.
// ----------------------------------------------------------------------------
package mtfw_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int WAIT_DEPTH = 8;
    localparam int PID_BITS   = 6;
    localparam int TAG_BITS   = 16;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int RPTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int RCNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int MEM_W  = SLOT_W + RPTR_W;

    typedef enum logic [1:0] {
        REQ_OPEN   = 2'd0,
        REQ_CLOSE  = 2'd1,
        REQ_LOCK   = 2'd2,
        REQ_UNLOCK = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_OPEN = 2'd1,
        ST_FULL     = 2'd2,
        ST_QFULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  key;
        logic [15:0] name_tag;
        logic [5:0]  pid;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic       blocked;
        logic       woken_valid;
        logic [5:0] woken_pid;
    } t_out_item;

    // Classified command passed from front to back.
    typedef struct packed {
        t_req                req;
        logic                key_ok;
        logic [SLOT_W-1:0]   key;
        logic [TAG_BITS-1:0] tag;
        logic [PID_BITS-1:0] pid;
    } t_cmd;

endpackage
`default_nettype wire

@@ design/mutex_table_fifo_waiters_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mutex_table_fifo_waiters_core
// Named mutex table with a bounded FIFO of waiting process ids per slot.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue and are executed one at a time,
// each as a table search and ring read, then the
// read-modify-write of the slot state. One result is held until popped; the
// next request starts in the cycle of the pop. The front keeps accepting
// requests meanwhile. No clearing pass after reset.
module mutex_table_fifo_waiters_core import mtfw_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_item  i_in,
    output logic           empty,
    input  wire logic      pop,
    output t_out_item      o_out
);
    logic o_cmd_valid_w, w_take;
    t_cmd w_cmd;

    mtfw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in(i_in),
        .o_cmd_valid(o_cmd_valid_w), .o_cmd(w_cmd), .i_cmd_take(w_take)
    );

    mtfw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(o_cmd_valid_w),
        .i_cmd(w_cmd), .o_cmd_take(w_take), .empty(empty), .pop(pop),
        .o_out(o_out)
    );

endmodule
`default_nettype wire

@@ design/mtfw_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtfw_front
// Accepts items, masks fields, range-checks the key and queues commands.
// ----------------------------------------------------------------------------
module mtfw_front import mtfw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_in,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd,
    input  wire logic     i_cmd_take
);
    // two-entry command queue
    t_cmd       r_q [2];
    logic       r_rd, n_rd;
    logic       r_wr, n_wr;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.req    = t_req'(i_in.req_type);
        w_cmd.key_ok = ({28'd0, i_in.key} < NUM_SLOTS);
        w_cmd.key    = SLOT_W'(i_in.key);
        w_cmd.tag    = TAG_BITS'(i_in.name_tag);
        w_cmd.pid    = PID_BITS'(i_in.pid);
    end

    assign full        = (r_cnt == 2'd2);
    assign w_push      = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_rd  = r_rd ^ i_cmd_take;
        n_wr  = r_wr ^ w_push;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_cmd_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_take |-> o_cmd_valid) else $error("take from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full && !i_cmd_take |=> full) else $error("full dropped without take");

endmodule
`default_nettype wire

@@ design/mtfw_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtfw_back
// Executes commands on the slot table and wait rings; holds one result.
// ----------------------------------------------------------------------------
module mtfw_back import mtfw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_take,
    output logic      empty,
    input  wire logic pop,
    output t_out_item o_out
);
    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_DONE = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [NUM_SLOTS-1:0] r_use, r_held;
    logic [TAG_BITS-1:0] r_name [NUM_SLOTS];
    logic [RPTR_W-1:0]   r_head [NUM_SLOTS];
    logic [RPTR_W-1:0]   r_tail [NUM_SLOTS];
    logic [RCNT_W-1:0]   r_rcnt [NUM_SLOTS];
    logic [PID_BITS-1:0] r_ring [NUM_SLOTS*WAIT_DEPTH];
    logic [PID_BITS-1:0] r_rdata;
    t_cmd                r_cmd;
    logic                r_full;
    t_out_item           r_out;

    // open search
    logic              w_found, w_free;
    logic [SLOT_W-1:0] w_match, w_fslot;
    always_comb begin
        w_found = 1'b0;
        w_free  = 1'b0;
        w_match = '0;
        w_fslot = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (!r_use[k]) begin
                w_free  = 1'b1;
                w_fslot = SLOT_W'(k);
            end else if (!w_found && r_name[k] == i_cmd.tag) begin
                w_found = 1'b1;
                w_match = SLOT_W'(k);
            end
        end
    end

    // at command take: read head entry of the ring for the queued command
    logic [RPTR_W-1:0] w_hptr;
    assign w_hptr = r_head[i_cmd.key];
    assign o_cmd_take = (r_state == S_EXEC) && i_cmd_valid && (!r_full || pop);

    logic [SLOT_W-1:0] s;
    logic              w_use, w_held;
    logic [RCNT_W-1:0] w_cnt;
    t_out_item         w_res;
    logic              w_exec;
    assign s      = r_cmd.key;
    assign w_use  = r_use[s];
    assign w_held = r_held[s];
    assign w_cnt  = r_rcnt[s];
    assign w_exec = (r_state == S_DONE);

    always_comb begin
        w_res = '0;
        if (r_cmd.req == REQ_OPEN) begin
            if (r_cmd.key_ok) w_res.slot = 4'(r_cmd.key);
            else if (r_cmd.pid[0]) w_res.slot = 4'(r_cmd.key);
            else w_res.status = ST_FULL;
        end else if (!r_cmd.key_ok || !w_use) begin
            w_res.status = ST_NOT_OPEN;
        end else if (r_cmd.req == REQ_LOCK) begin
            if (w_held && w_cnt >= RCNT_W'(WAIT_DEPTH)) w_res.status = ST_QFULL;
            else if (w_held) w_res.blocked = 1'b1;
        end else if (r_cmd.req == REQ_UNLOCK) begin
            if (w_cnt != '0) begin
                w_res.woken_valid = 1'b1;
                w_res.woken_pid   = 6'(r_rdata);
            end
        end
    end

    // open results are resolved at command take and carried in key_ok/key/pid[0]
    t_cmd w_lat;
    always_comb begin
        w_lat = i_cmd;
        if (i_cmd.req == REQ_OPEN) begin
            w_lat.key_ok = w_found;
            w_lat.key    = w_found ? w_match : w_fslot;
            w_lat.pid    = '0;
            w_lat.pid[0] = w_free;
        end
    end

    function automatic logic [RPTR_W-1:0] nxt(input logic [RPTR_W-1:0] p);
        nxt = ({1'b0, p} + 1'b1 >= (RPTR_W+1)'(WAIT_DEPTH)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EXEC: if (o_cmd_take) n_state = S_DONE;
            S_DONE: n_state = S_EXEC;
            default: n_state = S_EXEC;
        endcase
    end

    assign empty = !r_full;
    assign o_out = r_out;

    logic [SLOT_W-1:0] w_oslot;
    assign w_oslot = r_cmd.key;

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd   <= w_lat;
            r_rdata <= r_ring[{i_cmd.key, w_hptr}];
        end
        if (w_exec) begin
            r_out <= w_res;
            if (r_cmd.req == REQ_OPEN && !r_cmd.key_ok && r_cmd.pid[0]) begin
                r_name[w_oslot] <= r_cmd.tag;
            end
            if (r_cmd.req == REQ_LOCK && r_cmd.key_ok && w_use && w_held
                && w_cnt < RCNT_W'(WAIT_DEPTH)) begin
                r_ring[{s, r_tail[s]}] <= r_cmd.pid;
            end
        end
        if (!i_rst_n) begin
            r_state <= S_EXEC;
            r_full  <= 1'b0;
            r_use   <= '0;
            r_held  <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_rcnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (pop && r_full) r_full <= 1'b0;
            if (w_exec) begin
                r_full <= 1'b1;
                if (r_cmd.req == REQ_OPEN) begin
                    if (!r_cmd.key_ok && r_cmd.pid[0]) begin
                        r_use[w_oslot]  <= 1'b1;
                        r_held[w_oslot] <= 1'b0;
                        r_head[w_oslot] <= '0;
                        r_tail[w_oslot] <= '0;
                        r_rcnt[w_oslot] <= '0;
                    end
                end else if (r_cmd.key_ok && w_use) begin
                    unique case (r_cmd.req)
                        REQ_CLOSE: r_use[s] <= 1'b0;
                        REQ_LOCK: begin
                            if (!w_held) r_held[s] <= 1'b1;
                            else if (w_cnt < RCNT_W'(WAIT_DEPTH)) begin
                                r_tail[s] <= nxt(r_tail[s]);
                                r_rcnt[s] <= w_cnt + 1'b1;
                            end
                        end
                        REQ_UNLOCK: begin
                            r_held[s] <= 1'b0;
                            if (w_cnt != '0) begin
                                r_head[s] <= nxt(r_head[s]);
                                r_rcnt[s] <= w_cnt - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    a_no_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> !r_full || pop) else $error("take with result pending");
    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> r_state == S_DONE) else $error("missed execute");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_full) else $error("result lost");

endmodule
`default_nettype wire

@@ test/tb_mutex_table_fifo_waiters_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mutex_table_fifo_waiters_core
// Self-checking bench for the mutex table: a behavioral copy of the table
// predicts every result, random requests and pop stalls exercise the queues.
// ----------------------------------------------------------------------------

module tb_mutex_table_fifo_waiters_core;
    import mtfw_pkg::*;

    int errors;

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    class mutex_scoreboard;
        bit            in_use [NUM_SLOTS];
        bit [15:0]     names  [NUM_SLOTS];
        bit            held   [NUM_SLOTS];
        bit [5:0]      waiters[NUM_SLOTS][WAIT_DEPTH];
        int            head   [NUM_SLOTS];
        int            tail   [NUM_SLOTS];
        int            count  [NUM_SLOTS];
        t_out_item     pending[$];

        function void note_request(t_in_item it);
            t_out_item r;
            int        s;
            bit        found;
            bit        have_free;
            int        match;
            int        open_slot;
            r = '0;
            r.status = ST_OK;
            s = it.key;
            found = 0;
            have_free = 0;
            match = 0;
            open_slot = 0;
            if (t_req'(it.req_type) == REQ_OPEN) begin
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (!in_use[k]) begin
                        open_slot = k;
                        have_free = 1;
                    end else if (!found && names[k] == it.name_tag) begin
                        match = k;
                        found = 1;
                    end
                end
                if (found) begin
                    r.slot = 4'(match);
                end else if (have_free) begin
                    in_use[open_slot] = 1;
                    names[open_slot] = it.name_tag;
                    held[open_slot] = 0;
                    head[open_slot] = 0;
                    tail[open_slot] = 0;
                    count[open_slot] = 0;
                    r.slot = 4'(open_slot);
                end else begin
                    r.status = ST_FULL;
                end
            end else if (!in_use[s]) begin
                r.status = ST_NOT_OPEN;
            end else if (t_req'(it.req_type) == REQ_CLOSE) begin
                in_use[s] = 0;
            end else if (t_req'(it.req_type) == REQ_LOCK) begin
                if (!held[s]) begin
                    held[s] = 1;
                end else if (count[s] >= WAIT_DEPTH) begin
                    r.status = ST_QFULL;
                end else begin
                    waiters[s][tail[s]] = it.pid;
                    tail[s] = (tail[s] + 1) % WAIT_DEPTH;
                    count[s]++;
                    r.blocked = 1;
                end
            end else begin
                held[s] = 0;
                if (count[s] > 0) begin
                    r.woken_pid = waiters[s][head[s]];
                    head[s] = (head[s] + 1) % WAIT_DEPTH;
                    count[s]--;
                    r.woken_valid = 1;
                end
            end
            pending.push_back(r);
        endfunction

        task check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status)
                report($sformatf("status %0d exp %0d", got.status, e.status));
            if (got.slot != e.slot)
                report($sformatf("slot %0d exp %0d", got.slot, e.slot));
            if (got.blocked != e.blocked)
                report($sformatf("blocked %0d exp %0d", got.blocked, e.blocked));
            if (got.woken_valid != e.woken_valid)
                report($sformatf("woken_valid %0d exp %0d", got.woken_valid,
                                 e.woken_valid));
            if (got.woken_pid != e.woken_pid)
                report($sformatf("woken_pid %0d exp %0d", got.woken_pid, e.woken_pid));
        endtask
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      push = 0;
    logic      pop = 0;
    logic      full;
    logic      empty;
    t_in_item  i_in = '0;
    t_out_item o_out;

    int push_idle = 0;
    int pop_idle = 0;
    longint cycles = 0;
    mutex_scoreboard sb = new();

    mutex_table_fifo_waiters_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_in    (i_in),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: checks at the edge, then picks pop for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_result(o_out);
        pop <= i_rst_n && ($urandom_range(99) >= pop_idle);
    end

    task automatic send(input t_req rq, input int key, input int tag, input int pid);
        t_in_item it;
        it.req_type = rq;
        it.key = 4'(key);
        it.name_tag = 16'(tag);
        it.pid = 6'(pid);
        while ($urandom_range(99) < push_idle) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        i_in <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(it);
    endtask

    task automatic drain();
        push <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Tags from a small pool so opens hit existing names often.
    function automatic int pick_tag();
        return ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                        : 16'hA500 + $urandom_range(19);
    endfunction

    task automatic random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 20) send(REQ_OPEN, $urandom_range(15), pick_tag(), $urandom_range(63));
            else if (r < 30) send(REQ_CLOSE, $urandom_range(15), $urandom_range(16'hFFFF),
                                 $urandom_range(63));
            else if (r < 70) send(REQ_LOCK, $urandom_range(15), $urandom_range(16'hFFFF),
                                 $urandom_range(63));
            else send(REQ_UNLOCK, $urandom_range(15), $urandom_range(16'hFFFF),
                      $urandom_range(63));
        end
    endtask

    initial begin
        errors = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        push_idle = 30;
        pop_idle = 68;
        // directed
        send(REQ_LOCK, 3, 0, 0);
        send(REQ_UNLOCK, 15, 0, 0);
        send(REQ_CLOSE, 0, 0, 0);
        send(REQ_OPEN, 0, 16'hFFFF, 63);
        send(REQ_OPEN, 15, 16'h0000, 0);
        send(REQ_OPEN, 0, 16'hFFFF, 0);
        send(REQ_LOCK, 15, 0, 63);
        for (int p = 0; p < 9; p++) send(REQ_LOCK, 15, 0, (p * 21) & 63);
        send(REQ_UNLOCK, 15, 0, 0);
        send(REQ_UNLOCK, 15, 0, 0);
        send(REQ_CLOSE, 15, 0, 0);
        send(REQ_LOCK, 15, 0, 5);
        for (int k = 0; k < 16; k++) send(REQ_OPEN, 0, 16'h1000 + k, 0);
        send(REQ_OPEN, 0, 16'h1010, 0);
        send(REQ_UNLOCK, 0, 0, 0);
        for (int k = 0; k < 16; k++) send(REQ_CLOSE, k, 0, 0);
        drain();
        random_phase(550);
        push_idle = 68;
        pop_idle = 30;
        random_phase(550);
        drain();
        push_idle = 0;
        pop_idle = 0;
        random_phase(550);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
